// ----- design/nps_pkg.sv -----
package nps_pkg;

  // distance limit register
  localparam int unsigned LIMIT_W = 34;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 34'd22027;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // control tag that travels with each scanned point
  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

endpackage

// ----- design/nps_ram.sv -----
module nps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/nps_dist.sv -----
module nps_dist #(
  parameter int CB = 16,
  parameter int IW = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nps_pkg::tag_t        in_tag,
  input  logic [IW-1:0]        in_index,
  input  logic [CB-1:0]        ref_x,
  input  logic [CB-1:0]        ref_y,
  input  logic [CB-1:0]        qry_x,
  input  logic [CB-1:0]        qry_y,
  output nps_pkg::tag_t        out_tag,
  output logic [IW-1:0]        out_index,
  output logic [2*CB:0]        out_dist
);
  import nps_pkg::*;

  // stage 1: absolute differences
  logic [CB:0]   diff_x;
  logic [CB:0]   diff_y;
  logic [CB-1:0] abs_x;
  logic [CB-1:0] abs_y;
  tag_t          s1_tag;
  logic [IW-1:0] s1_index;

  // stage 2: squares
  logic [2*CB-1:0] sq_x;
  logic [2*CB-1:0] sq_y;
  tag_t            s2_tag;
  logic [IW-1:0]   s2_index;

  // sign-extended differences, magnitude always fits cb bits
  assign diff_x = {ref_x[CB-1], ref_x} - {qry_x[CB-1], qry_x};
  assign diff_y = {ref_y[CB-1], ref_y} - {qry_y[CB-1], qry_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag  <= '0;
      s2_tag  <= '0;
      out_tag <= '0;
    end else begin
      s1_tag  <= in_tag;
      s2_tag  <= s1_tag;
      out_tag <= s2_tag;
    end
  end

  always_ff @(posedge clk) begin
    abs_x     <= diff_x[CB] ? CB'(~diff_x + 1'b1) : diff_x[CB-1:0];
    abs_y     <= diff_y[CB] ? CB'(~diff_y + 1'b1) : diff_y[CB-1:0];
    s1_index  <= in_index;
    sq_x      <= {{CB{1'b0}}, abs_x} * {{CB{1'b0}}, abs_x};
    sq_y      <= {{CB{1'b0}}, abs_y} * {{CB{1'b0}}, abs_y};
    s2_index  <= s1_index;
    out_dist  <= {1'b0, sq_x} + {1'b0, sq_y};
    out_index <= s2_index;
  end

endmodule

// ----- design/nearest_point_search.sv -----
// Brute-force 2-D nearest point search. Reference points are loaded one per
// item into a table of MAX_POINTS entries (loads past capacity are dropped,
// a clear item empties the table). A query scans the table in load order,
// one stored point per clock through a pipelined distance unit (registered
// table read, absolute difference, squaring, sum), and answers with the
// 1-based index of the first point whose exact squared distance is strictly
// smallest and strictly below distance_limit, or 0 when none qualifies.
// A load or clear completes in the cycle it is accepted. A query holds
// the input stalled until its result is written (an empty table skips the
// scan), longer while an earlier result still waits: the stored points pass
// one per clock through each coordinate table's single read port, then
// come the registered read, three distance stages and the result write.
// The result sits in an output register, so the next item can be taken
// while a result still waits. No clearing pass is needed after reset:
// only entries below the fill count are ever used in a distance compare.
module nearest_point_search #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        kind,
  input  logic signed [COORD_BITS-1:0]      point_x,
  input  logic signed [COORD_BITS-1:0]      point_y,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [$clog2(MAX_POINTS+1)-1:0]   closest_index,
  // distance limit write channel
  input  logic                              limit_valid,
  output logic                              limit_ready,
  input  logic [nps_pkg::LIMIT_W-1:0]       limit_data
);
  import nps_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int IDX_W  = $clog2(MAX_POINTS + 1);
  localparam int DIST_W = 2 * COORD_BITS + 1;
  localparam int BEST_W = (DIST_W > LIMIT_W) ? DIST_W : LIMIT_W;

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [LIMIT_W-1:0]  distance_limit;
  logic [IDX_W-1:0]    point_count;
  logic [COORD_BITS-1:0] qry_x;
  logic [COORD_BITS-1:0] qry_y;
  logic [ADDR_W-1:0]   scan_addr;
  logic                scan_last;
  logic [IDX_W-1:0]    scan_index;

  // tag lined up with the registered table read
  tag_t                rd_tag;
  logic [IDX_W-1:0]    rd_index;
  logic [COORD_BITS-1:0] ref_x;
  logic [COORD_BITS-1:0] ref_y;

  // distance unit output
  tag_t                d_tag;
  logic [IDX_W-1:0]    d_index;
  logic [DIST_W-1:0]   d_dist;

  logic [BEST_W-1:0]   best;
  logic [IDX_W-1:0]    best_index;

  logic item_accept;
  logic load_we;
  logic out_free;
  logic better;

  // the user must write the limit only while the block is idle; the block does not enforce this
  assign limit_ready = 1'b1;

  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign load_we     = item_accept && (kind == KIND_LOAD) &&
                       (point_count < IDX_W'(MAX_POINTS));

  assign scan_index = IDX_W'(scan_addr) + 1'b1;
  assign scan_last  = (scan_index == point_count);

  // output register is free when empty or being taken this cycle
  assign out_free = !result_valid || !result_stall;

  // strict compare keeps the earlier point on ties
  assign better = d_tag.valid && (BEST_W'(d_dist) < best);

  // reference coordinate tables
  nps_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk   (clk),
    .we    (load_we),
    .waddr (point_count[ADDR_W-1:0]),
    .wdata (point_x),
    .raddr (scan_addr),
    .rdata (ref_x)
  );

  nps_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk   (clk),
    .we    (load_we),
    .waddr (point_count[ADDR_W-1:0]),
    .wdata (point_y),
    .raddr (scan_addr),
    .rdata (ref_y)
  );

  nps_dist #(.CB(COORD_BITS), .IW(IDX_W)) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_tag    (rd_tag),
    .in_index  (rd_index),
    .ref_x     (ref_x),
    .ref_y     (ref_y),
    .qry_x     (qry_x),
    .qry_y     (qry_y),
    .out_tag   (d_tag),
    .out_index (d_index),
    .out_dist  (d_dist)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_accept && (kind == KIND_QUERY)) begin
          // empty table answers at once
          state_next = (point_count == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (d_tag.valid && d_tag.last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      distance_limit <= LIMIT_RESET;
      point_count    <= '0;
      rd_tag         <= '0;
      result_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (limit_valid && limit_ready) begin
        distance_limit <= limit_data;
      end
      // loads and clears finish in the cycle they transfer
      if (load_we) begin
        point_count <= point_count + 1'b1;
      end else if (item_accept && (kind == KIND_CLEAR)) begin
        point_count <= '0;
      end
      rd_tag.valid <= (state == S_SCAN);
      rd_tag.last  <= (state == S_SCAN) && scan_last;
      if ((state == S_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (item_accept && (kind == KIND_QUERY)) begin
      qry_x      <= point_x;
      qry_y      <= point_y;
      scan_addr  <= '0;
      best       <= BEST_W'(distance_limit);
      best_index <= '0;
    end else begin
      if (state == S_SCAN) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (better) begin
        best       <= BEST_W'(d_dist);
        best_index <= d_index;
      end
    end
    rd_index <= scan_index;
    if ((state == S_DONE) && out_free) begin
      closest_index <= best_index;
    end
  end

endmodule
